// File: rtl/gap_buffer_text_store_unit_defines.svh
// assertion macros used by the top level of the gap buffer text store rtl
`ifndef GAP_BUFFER_TEXT_STORE_UNIT_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GBTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gap buffer text store: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define GBTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gap buffer text store: next-cycle check failed");

`endif

// File: rtl/gbts_pkg.sv
// types, constants and helpers of the gap buffer text store
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 13;
    localparam int BYTE_W   = 8;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    localparam logic [BYTE_W-1:0] CASE_DISTANCE = 8'd32;
    localparam logic [BYTE_W-1:0] UPPER_FIRST   = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_LAST    = 8'h5A;

    typedef enum logic [2:0] {
        KIND_INSERT  = 3'd0,
        KIND_DELETE  = 3'd1,
        KIND_READ    = 3'd2,
        KIND_COMPARE = 3'd3,
        KIND_SEEK    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_COPY,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] read_byte;
        logic              matched;
        logic [POS_W-1:0]  text_length;
    } result_t;

    typedef struct packed {
        logic [LEN_W-1:0] gap_first;
        logic [LEN_W-1:0] gap_past_end;
    } gap_state_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
        if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
            return c + CASE_DISTANCE;
        end
        return c;
    endfunction

endpackage

// File: rtl/gbts_text_ram.sv
// text memory: one write port, one read port with registered read data
module gbts_text_ram (
    input  logic                              aclk,
    input  gbts_pkg::ram_req_t                req,
    output logic [gbts_pkg::BYTE_W-1:0]       rdata
);

    logic [gbts_pkg::BYTE_W-1:0] mem [gbts_pkg::CAPACITY];
    logic [gbts_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gbts_ctrl.sv
// control sequencer: gap registers, gap moves and operation execution
module gbts_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_kind,
    input  logic [gbts_pkg::POS_W-1:0]    s_position,
    input  logic [gbts_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [gbts_pkg::POS_W-1:0]    s_count,
    input  logic                          s_fold_case,
    input  logic                          res_ready,
    output logic                          res_valid,
    output gbts_pkg::result_t             res,
    output gbts_pkg::gap_state_t          gap,
    output gbts_pkg::ram_req_t            ram_req,
    input  logic [gbts_pkg::BYTE_W-1:0]   ram_rdata
);

    localparam int LW = gbts_pkg::LEN_W;
    localparam int AW = gbts_pkg::ADDR_W;
    localparam int BW = gbts_pkg::BYTE_W;
    localparam int PW = gbts_pkg::POS_W;

    gbts_pkg::state_t state_reg, state_next;
    gbts_pkg::kind_t  kind_reg, kind_next, kind_in;
    logic [LW-1:0]    gf_reg, gf_next;
    logic [LW-1:0]    gpe_reg, gpe_next;
    logic [LW-1:0]    target_reg, target_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic [BW-1:0]    dbyte_reg, dbyte_next;
    logic             fold_reg, fold_next;
    logic             hit_reg, hit_next;
    logic             full_reg, full_next;

    logic [LW-1:0]    len;
    logic [LW-1:0]    gap_span;
    logic [LW-1:0]    pos_in;
    logic [LW-1:0]    cnt_in;
    logic [LW-1:0]    clamped;
    logic [LW-1:0]    remain;
    logic [LW-1:0]    phys;
    logic [BW-1:0]    byte_got;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbts_pkg::ST_IDLE;
            gf_reg    <= '0;
            gpe_reg   <= gbts_pkg::CAP_LEN;
        end else begin
            state_reg <= state_next;
            gf_reg    <= gf_next;
            gpe_reg   <= gpe_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        target_reg <= target_next;
        cnt_reg    <= cnt_next;
        dbyte_reg  <= dbyte_next;
        fold_reg   <= fold_next;
        hit_reg    <= hit_next;
        full_reg   <= full_next;
    end

    always_comb begin
        gap_span = gpe_reg - gf_reg;
        len      = gbts_pkg::CAP_LEN - gap_span;
        kind_in  = gbts_pkg::kind_t'(s_kind);
        pos_in   = LW'(s_position);
        cnt_in   = LW'(s_count);
        clamped  = (pos_in > len) ? len : pos_in;
        remain   = len - pos_in;
        phys     = (pos_in < gf_reg) ? pos_in : pos_in + gap_span;
        byte_got = hit_reg ? ram_rdata : '0;
    end

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        gf_next     = gf_reg;
        gpe_next    = gpe_reg;
        target_next = target_reg;
        cnt_next    = cnt_reg;
        dbyte_next  = dbyte_reg;
        fold_next   = fold_reg;
        hit_next    = hit_reg;
        full_next   = full_reg;
        ram_req     = '0;
        res         = '0;
        res_valid   = 1'b0;
        s_ready     = 1'b0;

        case (state_reg)
            gbts_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next   = kind_in;
                    dbyte_next  = s_data_byte;
                    fold_next   = s_fold_case;
                    hit_next    = (pos_in < len);
                    full_next   = (gf_reg == gpe_reg);
                    target_next = gf_reg;
                    cnt_next    = '0;
                    state_next  = gbts_pkg::ST_MOVE;
                    case (kind_in)
                        gbts_pkg::KIND_INSERT: begin
                            if (gf_reg != gpe_reg) begin
                                target_next = clamped;
                            end
                        end
                        gbts_pkg::KIND_DELETE: begin
                            if (cnt_in != '0 && pos_in < len) begin
                                target_next = pos_in;
                                cnt_next    = (cnt_in > remain) ? remain : cnt_in;
                            end
                        end
                        gbts_pkg::KIND_SEEK: begin
                            target_next = clamped;
                        end
                        gbts_pkg::KIND_READ, gbts_pkg::KIND_COMPARE: begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = phys[AW-1:0];
                            state_next    = gbts_pkg::ST_FETCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            gbts_pkg::ST_MOVE: begin
                if (target_reg != gf_reg) begin
                    // fetch the byte that crosses the gap
                    ram_req.re    = 1'b1;
                    ram_req.raddr = (target_reg < gf_reg) ? AW'(gf_reg - 1'b1)
                                                          : gpe_reg[AW-1:0];
                    state_next    = gbts_pkg::ST_COPY;
                end else if (res_ready) begin
                    res_valid = 1'b1;
                    case (kind_reg)
                        gbts_pkg::KIND_INSERT: begin
                            if (full_reg) begin
                                res.status = 1'b1;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = gf_reg[AW-1:0];
                                ram_req.wdata = dbyte_reg;
                                gf_next       = gf_reg + 1'b1;
                            end
                        end
                        gbts_pkg::KIND_DELETE: begin
                            gpe_next = gpe_reg + cnt_reg;
                        end
                        default: begin
                        end
                    endcase
                    res.text_length = PW'(gbts_pkg::CAP_LEN - (gpe_next - gf_next));
                    state_next      = gbts_pkg::ST_IDLE;
                end
            end

            gbts_pkg::ST_COPY: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata;
                if (target_reg < gf_reg) begin
                    ram_req.waddr = AW'(gpe_reg - 1'b1);
                    gf_next       = gf_reg - 1'b1;
                    gpe_next      = gpe_reg - 1'b1;
                end else begin
                    ram_req.waddr = gf_reg[AW-1:0];
                    gf_next       = gf_reg + 1'b1;
                    gpe_next      = gpe_reg + 1'b1;
                end
                state_next = gbts_pkg::ST_MOVE;
            end

            gbts_pkg::ST_FETCH: begin
                if (res_ready) begin
                    res_valid = 1'b1;
                    if (kind_reg == gbts_pkg::KIND_READ) begin
                        res.read_byte = byte_got;
                    end else begin
                        res.matched = hit_reg && (fold_reg
                            ? (gbts_pkg::fold_byte(byte_got) ==
                               gbts_pkg::fold_byte(dbyte_reg))
                            : (byte_got == dbyte_reg));
                    end
                    res.text_length = PW'(len);
                    state_next      = gbts_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gbts_pkg::ST_IDLE;
            end
        endcase
    end

    assign gap.gap_first    = gf_reg;
    assign gap.gap_past_end = gpe_reg;

endmodule

// File: rtl/gap_buffer_text_store_unit.sv
// top level of the gap buffer text store: sequencer, text memory, result register
//
//   channel  direction  ports                                           handshake
//   s_       in         kind position data_byte count fold_case         s_valid/s_ready
//   m_       out        status read_byte matched text_length            m_valid/m_ready
//
// read and compare address the text memory on acceptance and use its data in the fetch state;
// insert, delete and seek first move the gap to its target, one byte per move and copy step;
// each moved byte costs a memory read and a memory write on the single text memory
// one item is worked on at a time; the next is taken once its result has left the sequencer
// reset clears the sequencer state, the gap registers and the result valid flag; the text memory needs no clearing pass
// a result waits in the m_ register while m_ready is low, and the sequencer holds a
// finished item until that register frees up
`include "gap_buffer_text_store_unit_defines.svh"

module gap_buffer_text_store_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_kind,
    input  logic [gbts_pkg::POS_W-1:0]    s_position,
    input  logic [gbts_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [gbts_pkg::POS_W-1:0]    s_count,
    input  logic                          s_fold_case,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [gbts_pkg::BYTE_W-1:0]   m_read_byte,
    output logic                          m_matched,
    output logic [gbts_pkg::POS_W-1:0]    m_text_length
);

    // sequencer to result register
    logic                      res_valid;
    logic                      res_ready;
    gbts_pkg::result_t         res;
    gbts_pkg::gap_state_t      gap;

    // sequencer to text memory
    gbts_pkg::ram_req_t        ram_req;
    logic [gbts_pkg::BYTE_W-1:0] ram_rdata;

    // result register
    logic                      m_valid_reg, m_valid_next;
    gbts_pkg::result_t         m_res_reg, m_res_next;

    gbts_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_position  (s_position),
        .s_data_byte (s_data_byte),
        .s_count     (s_count),
        .s_fold_case (s_fold_case),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res         (res),
        .gap         (gap),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    gbts_text_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // the register can take a new result when empty or when its transfer completes now
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_read_byte   = m_res_reg.read_byte;
    assign m_matched     = m_res_reg.matched;
    assign m_text_length = m_res_reg.text_length;

    // gap never inverts and never runs past the end of the memory
    `GBTS_ASSERT_IMP(a_gap_order, aclk, aresetn, 1'b1, (gap.gap_first <= gap.gap_past_end) && (gap.gap_past_end <= gbts_pkg::CAP_LEN))

    // a refused insert only happens with a full store
    `GBTS_ASSERT_IMP(a_full_length, aclk, aresetn, m_valid && m_status, m_text_length == gbts_pkg::POS_W'(gbts_pkg::CAPACITY))

    // s_ready drops after every accepted item
    `GBTS_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a result only leaves the sequencer when the result register can take it
    `GBTS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, res_valid, res_ready)

endmodule
